// ----- rtl/core/star_direction_quad_builder_defines.svh -----
// Assertion macros used by the quad builder RTL
`ifndef STAR_DIRECTION_QUAD_BUILDER_DEFINES_SVH
`define STAR_DIRECTION_QUAD_BUILDER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SDQB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define SDQB_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/sdqb_pkg.sv -----
// Types and constants of the star direction quad builder
`default_nettype none
package sdqb_pkg;

  localparam int FRAC_BITS_DEF = 15;
  localparam int DIR_W         = 8;
  localparam int LEN_SQ_W      = 2 * DIR_W;
  localparam int RADIUS_W      = 14;
  localparam int HALF_W        = 8;
  localparam int CFG_W         = 14;
  localparam int COORD_W       = 16;
  localparam int COORD_MAX     = 32767;
  localparam int COORD_MIN_MAG = 32768;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(6000);
  localparam logic [HALF_W-1:0]   HALF_RESET   = HALF_W'(12);

  // |y| > 0.9 |d| tested exactly as 100 y^2 > 81 L
  localparam int TAN_NUM = 100;
  localparam int TAN_DEN = 81;

  typedef enum logic [0:0] {
    REG_RADIUS = 1'b0,
    REG_HALF   = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic                  zero;
    logic [2:0]            dneg;
    logic [2:0]            tneg;
    logic [2:0][DIR_W-1:0] a;
    logic [2:0][DIR_W-1:0] b;
  } side_t;

  typedef struct packed {
    logic       zero;
    logic [2:0] dneg;
    logic [2:0] tneg;
  } sign_t;

endpackage
`default_nettype wire

// ----- rtl/core/star_direction_quad_builder.sv -----
// Top level: direction vector to billboard quad corners, fully pipelined
//
// One direction is taken in every cycle (busy stays low) and its four corners
// appear for one cycle, marked by done; there is no back-pressure, so the
// receiver must take every transaction. The pipeline is the bit-per-stage
// square root (FRAC_BITS+8 stages), the bit-per-stage rounding dividers
// (FRAC_BITS+1 stages) and nine stages of setup, cross product and corner
// arithmetic. Registers must be written through cfg_we/cfg_index/cfg_data
// only while no transaction is in flight; the block does not enforce this.
`default_nettype none
module star_direction_quad_builder
  import sdqb_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic signed [DIR_W-1:0]    dir_x,
  input  wire logic signed [DIR_W-1:0]    dir_y,
  input  wire logic signed [DIR_W-1:0]    dir_z,
  input  wire logic                       cfg_we,
  input  wire logic [0:0]                 cfg_index,
  input  wire logic [CFG_W-1:0]           cfg_data,
  output logic                            done,
  output logic signed [COORD_W-1:0]       c0_x,
  output logic signed [COORD_W-1:0]       c0_y,
  output logic signed [COORD_W-1:0]       c0_z,
  output logic signed [COORD_W-1:0]       c1_x,
  output logic signed [COORD_W-1:0]       c1_y,
  output logic signed [COORD_W-1:0]       c1_z,
  output logic signed [COORD_W-1:0]       c2_x,
  output logic signed [COORD_W-1:0]       c2_y,
  output logic signed [COORD_W-1:0]       c2_z,
  output logic signed [COORD_W-1:0]       c3_x,
  output logic signed [COORD_W-1:0]       c3_y,
  output logic signed [COORD_W-1:0]       c3_z
);

`include "star_direction_quad_builder_defines.svh"

  localparam int F    = FRAC_BITS;
  localparam int VW   = LEN_SQ_W + 2 * F;      // radicand
  localparam int RW   = VW + 2;                // sqrt remainder
  localparam int SW   = LEN_SQ_W / 2 + F;      // sqrt result
  localparam int QW   = F + 1;                 // quotient magnitude
  localparam int NW   = 2 * F + DIR_W + 2;     // divider numerator
  localparam int UW   = F + 2;                 // signed unit component
  localparam int PW   = 2 * UW;
  localparam int T2W  = PW + 1;
  localparam int RUW  = RADIUS_W + 1 + UW;
  localparam int HT1W = HALF_W + 1 + UW;
  localparam int HT2W = HALF_W + 1 + T2W;
  localparam int AW   = 2 * F + RADIUS_W + 5;
  localparam int QOW  = AW - 2 * F;
  localparam int SELW = 2 * LEN_SQ_W - 8;

  logic [RADIUS_W-1:0] radius;
  logic [HALF_W-1:0]   half_size;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius    <= RADIUS_RESET;
      half_size <= HALF_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_RADIUS) begin
        radius <= cfg_data[RADIUS_W-1:0];
      end else begin
        half_size <= cfg_data[HALF_W-1:0];
      end
    end
  end

  // ---------------- entry: lengths and tangent choice
  logic [DIR_W-1:0]    ax, ay, az;
  logic [LEN_SQ_W-1:0] l_sum, m_sum, xx, yy, zz;
  logic                sel;
  side_t               side_in;

  always_comb begin
    ax = dir_x[DIR_W-1] ? DIR_W'(-dir_x) : dir_x;
    ay = dir_y[DIR_W-1] ? DIR_W'(-dir_y) : dir_y;
    az = dir_z[DIR_W-1] ? DIR_W'(-dir_z) : dir_z;
    xx = LEN_SQ_W'(ax) * LEN_SQ_W'(ax);
    yy = LEN_SQ_W'(ay) * LEN_SQ_W'(ay);
    zz = LEN_SQ_W'(az) * LEN_SQ_W'(az);
    l_sum = xx + yy + zz;
    sel = (SELW'(yy) * SELW'(TAN_NUM)) > (SELW'(l_sum) * SELW'(TAN_DEN));
    side_in.zero = (l_sum == '0);
    side_in.dneg = {dir_z[DIR_W-1], dir_y[DIR_W-1], dir_x[DIR_W-1]};
    side_in.a    = {az, ay, ax};
    if (sel) begin
      // (0, -z, y)
      side_in.b    = {ay, az, DIR_W'(0)};
      side_in.tneg = {dir_y[DIR_W-1], ~dir_z[DIR_W-1] && (dir_z != '0), 1'b0};
      m_sum        = yy + zz;
    end else begin
      // (z, 0, -x)
      side_in.b    = {ax, DIR_W'(0), az};
      side_in.tneg = {~dir_x[DIR_W-1] && (dir_x != '0), 1'b0, dir_z[DIR_W-1]};
      m_sum        = xx + zz;
    end
  end

  // ---------------- square root, one result bit per stage
  logic          sq_vld   [0:SW];
  logic [RW-1:0] sq_rem_l [0:SW];
  logic [RW-1:0] sq_rem_m [0:SW];
  logic [SW-1:0] sq_res_l [0:SW];
  logic [SW-1:0] sq_res_m [0:SW];
  side_t         sq_side  [0:SW];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld[0] <= 1'b0;
    end else begin
      sq_vld[0] <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    sq_rem_l[0] <= RW'(l_sum) << (2 * F);
    sq_rem_m[0] <= RW'(m_sum) << (2 * F);
    sq_res_l[0] <= '0;
    sq_res_m[0] <= '0;
    sq_side[0]  <= side_in;
  end

  for (genvar k = 0; k < SW; k++) begin : g_sqrt
    localparam int B = SW - 1 - k;
    logic [RW-1:0] trial_l, trial_m;
    logic          take_l, take_m;

    always_comb begin
      trial_l = (RW'(sq_res_l[k]) << (B + 1)) + (RW'(1) << (2 * B));
      trial_m = (RW'(sq_res_m[k]) << (B + 1)) + (RW'(1) << (2 * B));
      take_l  = sq_rem_l[k] >= trial_l;
      take_m  = sq_rem_m[k] >= trial_m;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_vld[k+1] <= 1'b0;
      end else begin
        sq_vld[k+1] <= sq_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      sq_rem_l[k+1] <= take_l ? sq_rem_l[k] - trial_l : sq_rem_l[k];
      sq_rem_m[k+1] <= take_m ? sq_rem_m[k] - trial_m : sq_rem_m[k];
      sq_res_l[k+1] <= take_l ? (sq_res_l[k] | (SW'(1) << B)) : sq_res_l[k];
      sq_res_m[k+1] <= take_m ? (sq_res_m[k] | (SW'(1) << B)) : sq_res_m[k];
      sq_side[k+1]  <= sq_side[k];
    end
  end

  // ---------------- rounding dividers: lanes 0..2 unit dir, 3..5 tangent
  logic                  dv_vld  [0:QW];
  logic [5:0][NW-1:0]    dv_rem  [0:QW];
  logic [5:0][QW-1:0]    dv_q    [0:QW];
  logic [NW-1:0]         dv_dl   [0:QW];
  logic [NW-1:0]         dv_dm   [0:QW];
  sign_t                 dv_sg   [0:QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld[0] <= 1'b0;
    end else begin
      dv_vld[0] <= sq_vld[SW];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      dv_rem[0][i]   <= (NW'(sq_side[SW].a[i]) << (2 * F + 1)) + NW'(sq_res_l[SW]);
      dv_rem[0][i+3] <= (NW'(sq_side[SW].b[i]) << (2 * F + 1)) + NW'(sq_res_m[SW]);
    end
    dv_q[0]       <= '0;
    dv_dl[0]      <= NW'(sq_res_l[SW]) << 1;
    dv_dm[0]      <= NW'(sq_res_m[SW]) << 1;
    dv_sg[0].zero <= sq_side[SW].zero;
    dv_sg[0].dneg <= sq_side[SW].dneg;
    dv_sg[0].tneg <= sq_side[SW].tneg;
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    localparam int J = QW - 1 - k;
    logic [5:0][NW-1:0] rem_next;
    logic [5:0][QW-1:0] q_next;

    always_comb begin
      logic [NW-1:0] dd;
      for (int i = 0; i < 6; i++) begin
        dd = (i < 3) ? (dv_dl[k] << J) : (dv_dm[k] << J);
        if (dv_rem[k][i] >= dd) begin
          rem_next[i] = dv_rem[k][i] - dd;
          q_next[i]   = dv_q[k][i] | (QW'(1) << J);
        end else begin
          rem_next[i] = dv_rem[k][i];
          q_next[i]   = dv_q[k][i];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[k+1] <= 1'b0;
      end else begin
        dv_vld[k+1] <= dv_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      dv_rem[k+1] <= rem_next;
      dv_q[k+1]   <= q_next;
      dv_dl[k+1]  <= dv_dl[k];
      dv_dm[k+1]  <= dv_dm[k];
      dv_sg[k+1]  <= dv_sg[k];
    end
  end

  // ---------------- signs, cross product, corners
  logic                       x1_vld, x2_vld, x3_vld, c1_vld, c2_vld, c3_vld;
  logic                       x1_zero, x2_zero, x3_zero, c1_zero, c2_zero, c3_zero;
  logic signed [UW-1:0]       x1_u  [3], x1_t1 [3];
  logic signed [UW-1:0]       x2_u  [3], x2_t1 [3];
  logic signed [UW-1:0]       x3_u  [3], x3_t1 [3];
  logic signed [PW-1:0]       x2_p  [6];
  logic signed [T2W-1:0]      x3_t2 [3];
  logic signed [RUW-1:0]      c1_ru [3];
  logic signed [HT1W-1:0]     c1_ht1 [3];
  logic signed [HT2W-1:0]     c1_ht2 [3];
  logic signed [AW-1:0]       c2_acc [4][3];
  logic [QOW-1:0]             c3_mag [4][3];
  logic                       c3_neg [4][3];
  logic [3:0][2:0][COORD_W-1:0] cor;

  always_ff @(posedge clk) begin
    if (rst) begin
      x1_vld <= 1'b0;
      x2_vld <= 1'b0;
      x3_vld <= 1'b0;
      c1_vld <= 1'b0;
      c2_vld <= 1'b0;
      c3_vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      x1_vld <= dv_vld[QW];
      x2_vld <= x1_vld;
      x3_vld <= x2_vld;
      c1_vld <= x3_vld;
      c2_vld <= c1_vld;
      c3_vld <= c2_vld;
      done   <= c3_vld;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      x1_u[i]  <= dv_sg[QW].dneg[i] ? -$signed({1'b0, dv_q[QW][i]})
                                    :  $signed({1'b0, dv_q[QW][i]});
      x1_t1[i] <= dv_sg[QW].tneg[i] ? -$signed({1'b0, dv_q[QW][i+3]})
                                    :  $signed({1'b0, dv_q[QW][i+3]});
    end
    x1_zero <= dv_sg[QW].zero;

    x2_p[0] <= x1_u[1] * x1_t1[2];
    x2_p[1] <= x1_u[2] * x1_t1[1];
    x2_p[2] <= x1_u[2] * x1_t1[0];
    x2_p[3] <= x1_u[0] * x1_t1[2];
    x2_p[4] <= x1_u[0] * x1_t1[1];
    x2_p[5] <= x1_u[1] * x1_t1[0];
    x2_u    <= x1_u;
    x2_t1   <= x1_t1;
    x2_zero <= x1_zero;

    for (int i = 0; i < 3; i++) begin
      x3_t2[i] <= T2W'(x2_p[2*i]) - T2W'(x2_p[2*i+1]);
    end
    x3_u    <= x2_u;
    x3_t1   <= x2_t1;
    x3_zero <= x2_zero;

    for (int i = 0; i < 3; i++) begin
      c1_ru[i]  <= $signed({1'b0, radius}) * x3_u[i];
      c1_ht1[i] <= $signed({1'b0, half_size}) * x3_t1[i];
      c1_ht2[i] <= $signed({1'b0, half_size}) * x3_t2[i];
    end
    c1_zero <= x3_zero;
  end

  // corner k: t1 added for corners 1 and 2, t2 added for corners 2 and 3
  always_ff @(posedge clk) begin
    logic signed [AW-1:0] base, e1, e2;
    for (int i = 0; i < 3; i++) begin
      base = AW'(c1_ru[i]) <<< F;
      e1   = AW'(c1_ht1[i]) <<< F;
      e2   = AW'(c1_ht2[i]);
      for (int k = 0; k < 4; k++) begin
        c2_acc[k][i] <= base + (((k == 1) || (k == 2)) ? e1 : -e1)
                             + ((k >= 2) ? e2 : -e2);
      end
    end
    c2_zero <= c1_zero;
  end

  // round half away from zero by 2F bits
  always_ff @(posedge clk) begin
    logic [AW-1:0] m;
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 3; i++) begin
        m = c2_acc[k][i][AW-1] ? AW'(-c2_acc[k][i]) : AW'(c2_acc[k][i]);
        m = m + (AW'(1) << (2 * F - 1));
        c3_mag[k][i] <= m[AW-1:2*F];
        c3_neg[k][i] <= c2_acc[k][i][AW-1];
      end
    end
    c3_zero <= c2_zero;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 3; i++) begin
        if (c3_zero) begin
          cor[k][i] <= '0;
        end else if (!c3_neg[k][i]) begin
          cor[k][i] <= (c3_mag[k][i] > QOW'(COORD_MAX)) ? COORD_W'(COORD_MAX)
                                                        : c3_mag[k][i][COORD_W-1:0];
        end else begin
          cor[k][i] <= (c3_mag[k][i] > QOW'(COORD_MIN_MAG)) ? COORD_W'(COORD_MIN_MAG)
                                                            : COORD_W'(-c3_mag[k][i]);
        end
      end
    end
  end

  assign c0_x = $signed(cor[0][0]);
  assign c0_y = $signed(cor[0][1]);
  assign c0_z = $signed(cor[0][2]);
  assign c1_x = $signed(cor[1][0]);
  assign c1_y = $signed(cor[1][1]);
  assign c1_z = $signed(cor[1][2]);
  assign c2_x = $signed(cor[2][0]);
  assign c2_y = $signed(cor[2][1]);
  assign c2_z = $signed(cor[2][2]);
  assign c3_x = $signed(cor[3][0]);
  assign c3_y = $signed(cor[3][1]);
  assign c3_z = $signed(cor[3][2]);

  // ---------------- checks
  `SDQB_ASSERT_NXT(a_entry_valid, start && !busy, sq_vld[0], "accepted transaction lost at entry")
  `SDQB_ASSERT_IMP(a_sqrt_exact, sq_vld[SW], sq_rem_l[SW] <= (RW'(sq_res_l[SW]) << 1), "sqrt not floor")
  `SDQB_ASSERT_IMP(a_div_rem_dir, dv_vld[QW] && !dv_sg[QW].zero, dv_rem[QW][0] < dv_dl[QW], "dir quotient short")
  `SDQB_ASSERT_IMP(a_div_rem_tan, dv_vld[QW] && !dv_sg[QW].zero, dv_rem[QW][3] < dv_dm[QW], "tangent quotient short")
  `SDQB_ASSERT_NXT(a_zero_corners, c3_vld && c3_zero, done && cor == '0, "zero direction gave nonzero corners")

endmodule
`default_nettype wire

// ----- sim/quad_corner_checker.sv -----
// Checker for the quad builder: predicts corners from accepted directions and compares
`timescale 1ns / 1ps
module quad_corner_checker
  import sdqb_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic                     busy,
  input  wire logic signed [DIR_W-1:0]  dir_x,
  input  wire logic signed [DIR_W-1:0]  dir_y,
  input  wire logic signed [DIR_W-1:0]  dir_z,
  input  wire logic                     cfg_we,
  input  wire logic [0:0]               cfg_index,
  input  wire logic [CFG_W-1:0]         cfg_data,
  input  wire logic                     done,
  input  wire logic signed [COORD_W-1:0] c0_x, c0_y, c0_z,
  input  wire logic signed [COORD_W-1:0] c1_x, c1_y, c1_z,
  input  wire logic signed [COORD_W-1:0] c2_x, c2_y, c2_z,
  input  wire logic signed [COORD_W-1:0] c3_x, c3_y, c3_z,
  output int                            errors,
  output int                            pending
);

  localparam int FB = FRAC_BITS_DEF;

  typedef logic [11:0][COORD_W-1:0] corners_t;

  logic [RADIUS_W-1:0] radius;
  logic [HALF_W-1:0]   half;
  corners_t            corner_queue[$];

  function automatic longint unsigned isqrt(input longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // divide rounding half away from zero, den > 0
  function automatic longint round_div(input longint num, input longint unsigned den);
    longint unsigned m;
    longint unsigned q;
    m = (num < 0) ? longint'(-num) : num;
    q = (m * 2 + den) / (den * 2);
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic void unit_vec(input longint v[3], input longint unsigned sq,
                                   output longint u[3]);
    longint unsigned len;
    len = isqrt(sq << (2 * FB));
    for (int i = 0; i < 3; i++) u[i] = round_div(v[i] * (longint'(1) << (2 * FB)), len);
  endfunction

  function automatic corners_t build_quad(input logic signed [7:0] x, y, z,
                                          input logic [RADIUS_W-1:0] r,
                                          input logic [HALF_W-1:0] hs);
    corners_t res;
    longint d[3], t[3], u[3], t1[3], t2[3];
    longint unsigned lsq, msq;
    longint acc, q;
    longint s1, s2;
    d[0] = x; d[1] = y; d[2] = z;
    lsq = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
    res = '0;
    if (lsq == 0) return res;
    unit_vec(d, lsq, u);
    if (longint'(d[1] * d[1]) * TAN_NUM > longint'(lsq) * TAN_DEN) begin
      t[0] = 0; t[1] = -d[2]; t[2] = d[1];
    end else begin
      t[0] = d[2]; t[1] = 0; t[2] = -d[0];
    end
    msq = t[0] * t[0] + t[1] * t[1] + t[2] * t[2];
    unit_vec(t, msq, t1);
    t2[0] = u[1] * t1[2] - u[2] * t1[1];
    t2[1] = u[2] * t1[0] - u[0] * t1[2];
    t2[2] = u[0] * t1[1] - u[1] * t1[0];
    for (int k = 0; k < 4; k++) begin
      s1 = (k == 1 || k == 2) ? 1 : -1;
      s2 = (k >= 2) ? 1 : -1;
      for (int i = 0; i < 3; i++) begin
        acc = longint'(r) * u[i] * (longint'(1) << FB);
        acc += s1 * longint'(hs) * t1[i] * (longint'(1) << FB);
        acc += s2 * longint'(hs) * t2[i];
        q = round_div(acc, longint'(1) << (2 * FB));
        if (q > COORD_MAX) q = COORD_MAX;
        if (q < -COORD_MIN_MAG) q = -COORD_MIN_MAG;
        res[k * 3 + i] = q[COORD_W-1:0];
      end
    end
    return res;
  endfunction

  corners_t got;
  assign got = {c3_z, c3_y, c3_x, c2_z, c2_y, c2_x, c1_z, c1_y, c1_x, c0_z, c0_y, c0_x};

  always @(posedge clk) begin
    corners_t want;
    int bad;
    if (rst) begin
      radius <= RADIUS_RESET;
      half   <= HALF_RESET;
      corner_queue.delete();
      errors <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_RADIUS) radius <= cfg_data[RADIUS_W-1:0];
        else half <= cfg_data[HALF_W-1:0];
      end
      if (start && !busy) corner_queue.push_back(build_quad(dir_x, dir_y, dir_z, radius, half));
      if (done) begin
        if (corner_queue.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, actual %h", $time, got);
          errors <= errors + 1;
        end else begin
          want = corner_queue.pop_front();
          bad = 0;
          for (int f = 0; f < 12; f++)
            if (want[f] !== got[f]) begin
              $display("%0t: corner %0d coord %0d expected %0d actual %0d", $time, f / 3,
                       f % 3, $signed(want[f]), $signed(got[f]));
              bad++;
            end
          errors <= errors + bad;
        end
      end
      pending <= corner_queue.size();
    end
  end

endmodule

// ----- sim/tb.sv -----
// Testbench top: drives directions and register writes, gives the verdict
`timescale 1ns / 1ps
module tb;
  import sdqb_pkg::*;

  localparam int LATENCY = 2 * FRAC_BITS_DEF + 18;
  localparam int LIMIT   = 300000;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic signed [DIR_W-1:0] dir_x = 0, dir_y = 0, dir_z = 0;
  logic cfg_we = 0;
  logic [0:0] cfg_index = 0;
  logic [CFG_W-1:0] cfg_data = 0;
  wire busy, done;
  wire signed [COORD_W-1:0] c0_x, c0_y, c0_z, c1_x, c1_y, c1_z;
  wire signed [COORD_W-1:0] c2_x, c2_y, c2_z, c3_x, c3_y, c3_z;
  int errors, pending;
  int cycles = 0;
  bit idle_en = 1;

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  star_direction_quad_builder dut (.*);
  quad_corner_checker chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_dir(input logic signed [7:0] x, y, z);
    logic b;
    start <= 1;
    dir_x <= x; dir_y <= y; dir_z <= z;
    forever begin
      @(negedge clk) b = busy;
      @(posedge clk);
      if (!b) break;
    end
    if (idle_en && $urandom_range(0, 3) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // stop issuing and let the pipeline empty
  task automatic drain();
    start <= 0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic random_dirs(input int n);
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 9);
      if (sel < 7)
        send_dir(8'($urandom), 8'($urandom), 8'($urandom));
      else if (sel < 9)  // short vectors, where rounding matters most
        send_dir(8'($urandom_range(0, 6) - 3), 8'($urandom_range(0, 6) - 3),
                 8'($urandom_range(0, 6) - 3));
      else  // near the tangent switch: y dominant
        send_dir(8'($urandom_range(0, 20) - 10), 8'($urandom),
                 8'($urandom_range(0, 20) - 10));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed, reset register values
    send_dir(0, 0, 0);
    send_dir(-128, -128, -128);
    send_dir(127, 127, 127);
    send_dir(127, 0, 0);
    send_dir(-128, 0, 0);
    send_dir(0, 127, 0);
    send_dir(0, -128, 0);
    send_dir(0, 0, 127);
    send_dir(0, 0, -128);
    send_dir(4, 9, 0);   // just inside the y-dominant tangent
    send_dir(5, 9, 0);   // just outside
    send_dir(1, 1, 1);
    send_dir(-1, 127, -128);
    send_dir(127, -128, 1);
    send_dir(0, 0, 0);
    drain();

    write_reg(REG_RADIUS, 1);
    write_reg(REG_HALF, 0);
    send_dir(127, 127, 127);
    send_dir(-128, 5, 3);
    send_dir(0, 0, 0);
    random_dirs(250);
    drain();

    write_reg(REG_RADIUS, 16000);
    write_reg(REG_HALF, 14'h3FFF);  // upper bits dropped, 255
    send_dir(-128, -128, -128);
    send_dir(0, -128, 0);
    random_dirs(250);
    drain();

    write_reg(REG_RADIUS, 14'h3FFF);
    write_reg(REG_HALF, 14'h3F00);
    random_dirs(250);
    drain();

    for (int p = 0; p < 3; p++) begin
      write_reg(REG_RADIUS, 14'($urandom_range(1, 16000)));
      write_reg(REG_HALF, 14'($urandom));
      if (p == 2) idle_en = 0;
      random_dirs(300);
      drain();
    end

    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
